// File: hw/rtl/lcg64_random_unit_defines.svh
// Assertion macros used by the random unit top level.
`ifndef LCG64_RANDOM_UNIT_DEFINES_SVH
`define LCG64_RANDOM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LCG_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lcg64 assertion failed");
`define LCG_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lcg64 forbidden condition seen");
`else
`define LCG_ASSERT(name, prop)
`define LCG_NEVER(name, expr)
`endif

`endif

// File: hw/rtl/lcg64ru_pkg.sv
package lcg64ru_pkg;

  localparam int unsigned LcgW      = 64;
  localparam int unsigned MulDigitW = 16;
  localparam int unsigned MulSteps  = LcgW / MulDigitW;
  localparam int unsigned MulCntW   = $clog2(MulSteps);
  localparam int unsigned DivCntW   = $clog2(LcgW);

  localparam int unsigned GaussW     = 56;
  localparam int unsigned FracW      = 52;
  localparam int unsigned Frac52Lsb  = LcgW - FracW;
  localparam int unsigned Frac23W    = 23;
  localparam int unsigned Frac23Lsb  = 9;
  localparam int unsigned GaussTerms = 12;
  localparam int unsigned GaussCntW  = $clog2(GaussTerms);

  localparam logic [LcgW-1:0]   LcgMul  = 64'haeb0_f5ce_cc1f_12ed;
  localparam logic [LcgW-1:0]   LcgAdd  = 64'hcda7_228a_2dfd_0e8b;
  localparam logic [LcgW-1:0]   AllOnes = '1;
  localparam logic [GaussW-1:0] SixQ52  = GaussW'(6) << FracW;

  typedef enum logic [2:0] {
    CmdSeed      = 3'd0,
    CmdRaw       = 3'd1,
    CmdRange     = 3'd2,
    CmdBetween   = 3'd3,
    CmdUniform52 = 3'd4,
    CmdUniform23 = 3'd5,
    CmdGauss52   = 3'd6,
    CmdGauss23   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StLimit,
    StStep,
    StMod,
    StFinish
  } state_e;

  typedef struct packed {
    logic            start;
    logic [LcgW-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [LcgW-1:0] result;
  } mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [LcgW-1:0] dividend;
    logic [LcgW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [LcgW-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hw/rtl/lcg64ru_mul.sv
module lcg64ru_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcg64ru_pkg::mul_req_t req_i,
  output lcg64ru_pkg::mul_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [lcg64ru_pkg::MulCntW-1:0]     step_q, step_d;
  logic [lcg64ru_pkg::LcgW-1:0]        acc_q, acc_d;
  logic [lcg64ru_pkg::LcgW-1:0]        mcand_q, mcand_d;
  logic [lcg64ru_pkg::LcgW-1:0]        mplier_q, mplier_d;
  logic [lcg64ru_pkg::LcgW-1:0]        partial;

  // One digit of the state times the shifted multiplier constant, kept modulo 2^64.
  assign partial = mcand_q *
      {{(lcg64ru_pkg::LcgW - lcg64ru_pkg::MulDigitW){1'b0}},
       mplier_q[lcg64ru_pkg::MulDigitW-1:0]};

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    step_d   = step_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      step_d   = '0;
      acc_d    = lcg64ru_pkg::LcgAdd;
      mcand_d  = lcg64ru_pkg::LcgMul;
      mplier_d = req_i.operand;
    end else if (busy_q) begin
      acc_d    = acc_q + partial;
      mcand_d  = mcand_q << lcg64ru_pkg::MulDigitW;
      mplier_d = mplier_q >> lcg64ru_pkg::MulDigitW;
      step_d   = step_q + 1'b1;
      if (step_q == lcg64ru_pkg::MulCntW'(lcg64ru_pkg::MulSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// File: hw/rtl/lcg64ru_div.sv
module lcg64ru_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcg64ru_pkg::div_req_t req_i,
  output lcg64ru_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [lcg64ru_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [lcg64ru_pkg::LcgW-1:0]    rem_q, rem_d;
  logic [lcg64ru_pkg::LcgW-1:0]    dvd_q, dvd_d;
  logic [lcg64ru_pkg::LcgW-1:0]    dsr_q, dsr_d;
  logic [lcg64ru_pkg::LcgW:0]      trial;
  logic [lcg64ru_pkg::LcgW:0]      diff;

  // Restoring division, one dividend bit per cycle; only the remainder is kept.
  assign trial = {rem_q, dvd_q[lcg64ru_pkg::LcgW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = diff[lcg64ru_pkg::LcgW] ? trial[lcg64ru_pkg::LcgW-1:0]
                                      : diff[lcg64ru_pkg::LcgW-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lcg64ru_pkg::DivCntW'(lcg64ru_pkg::LcgW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: hw/rtl/lcg64_random_unit.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   command_i, lower_bound_i, upper_bound_i, seed_value_i
// out      out_valid_o / out_ready_i rand_value_o, gauss_value_o, bound_error_o
//
// Each generator step runs on a 64x16 multiplier, one 16-bit digit of the state at a time.
// Seed commands and bound errors need no generator step, raw and uniform requests take one,
// Gaussian requests twelve, and ranged requests one per draw until a draw is accepted,
// with one restoring modulo pass before the draws and one after.
// Reset clears the generator state to zero; no clearing pass is needed.
// A finished result waits in the output register while the next command is taken.
`include "lcg64_random_unit_defines.svh"

module lcg64_random_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           command_i,
  input  logic [lcg64ru_pkg::LcgW-1:0]         lower_bound_i,
  input  logic [lcg64ru_pkg::LcgW-1:0]         upper_bound_i,
  input  logic [lcg64ru_pkg::LcgW-1:0]         seed_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lcg64ru_pkg::LcgW-1:0]         rand_value_o,
  output logic signed [lcg64ru_pkg::GaussW-1:0] gauss_value_o,
  output logic                                 bound_error_o
);

  lcg64ru_pkg::state_e               state_q, state_d;
  lcg64ru_pkg::cmd_e                 cmd_q, cmd_d;
  lcg64ru_pkg::cmd_e                 cmd_in;
  logic [lcg64ru_pkg::LcgW-1:0]      lcg_q, lcg_d;
  logic [lcg64ru_pkg::LcgW-1:0]      bound_q, bound_d;
  logic [lcg64ru_pkg::LcgW-1:0]      offset_q, offset_d;
  logic [lcg64ru_pkg::LcgW-1:0]      lim_q, lim_d;
  logic [lcg64ru_pkg::LcgW-1:0]      res_q, res_d;
  logic [lcg64ru_pkg::GaussW-1:0]    sum_q, sum_d;
  logic [lcg64ru_pkg::GaussCntW-1:0] cnt_q, cnt_d;
  logic                              err_q, err_d;
  logic                              out_valid_q, out_valid_d;
  logic [lcg64ru_pkg::LcgW-1:0]      rand_value_q, rand_value_d;
  logic [lcg64ru_pkg::GaussW-1:0]    gauss_value_q, gauss_value_d;
  logic                              bound_error_q, bound_error_d;
  logic [lcg64ru_pkg::LcgW-1:0]      bound_in;
  logic                              err_in;
  logic [lcg64ru_pkg::LcgW-1:0]      step_val;
  logic [lcg64ru_pkg::FracW-1:0]     frac52;
  logic [lcg64ru_pkg::Frac23W-1:0]   frac23;
  lcg64ru_pkg::mul_req_t             mul_req;
  lcg64ru_pkg::mul_rsp_t             mul_rsp;
  lcg64ru_pkg::div_req_t             div_req;
  lcg64ru_pkg::div_rsp_t             div_rsp;

  lcg64ru_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  lcg64ru_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cmd_in   = lcg64ru_pkg::cmd_e'(command_i);
  assign bound_in = (cmd_in == lcg64ru_pkg::CmdBetween) ? upper_bound_i - lower_bound_i
                                                         : upper_bound_i;
  assign err_in   = ((cmd_in == lcg64ru_pkg::CmdRange) && (upper_bound_i == '0)) ||
                    ((cmd_in == lcg64ru_pkg::CmdBetween) && (upper_bound_i <= lower_bound_i));

  assign step_val = mul_rsp.result;
  assign frac52   = step_val[lcg64ru_pkg::LcgW-1:lcg64ru_pkg::Frac52Lsb];
  assign frac23   = step_val[lcg64ru_pkg::Frac23Lsb+lcg64ru_pkg::Frac23W-1:
                             lcg64ru_pkg::Frac23Lsb];

  assign in_ready_o = (state_q == lcg64ru_pkg::StIdle);

  always_comb begin
    state_d          = state_q;
    cmd_d            = cmd_q;
    lcg_d            = lcg_q;
    bound_d          = bound_q;
    offset_d         = offset_q;
    lim_d            = lim_q;
    res_d            = res_q;
    sum_d            = sum_q;
    cnt_d            = cnt_q;
    err_d            = err_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    rand_value_d     = rand_value_q;
    gauss_value_d    = gauss_value_q;
    bound_error_d    = bound_error_q;
    mul_req.start    = 1'b0;
    mul_req.operand  = lcg_q;
    div_req.start    = 1'b0;
    div_req.dividend = lcg64ru_pkg::AllOnes;
    div_req.divisor  = bound_q;

    unique case (state_q)
      lcg64ru_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_d    = cmd_in;
          bound_d  = bound_in;
          offset_d = (cmd_in == lcg64ru_pkg::CmdBetween) ? lower_bound_i : '0;
          res_d    = '0;
          sum_d    = '0;
          cnt_d    = '0;
          err_d    = 1'b0;
          unique case (cmd_in) inside
            lcg64ru_pkg::CmdSeed: begin
              lcg_d   = seed_value_i;
              state_d = lcg64ru_pkg::StFinish;
            end
            lcg64ru_pkg::CmdRange, lcg64ru_pkg::CmdBetween: begin
              if (err_in) begin
                err_d   = 1'b1;
                state_d = lcg64ru_pkg::StFinish;
              end else begin
                div_req.start   = 1'b1;
                div_req.divisor = bound_in;
                state_d         = lcg64ru_pkg::StLimit;
              end
            end
            default: begin
              mul_req.start = 1'b1;
              state_d       = lcg64ru_pkg::StStep;
            end
          endcase
        end
      end

      lcg64ru_pkg::StLimit: begin
        if (div_rsp.done) begin
          // All ones minus the remainder is its bitwise complement.
          lim_d         = ~div_rsp.remainder;
          mul_req.start = 1'b1;
          state_d       = lcg64ru_pkg::StStep;
        end
      end

      lcg64ru_pkg::StStep: begin
        mul_req.operand = step_val;
        if (mul_rsp.done) begin
          lcg_d = step_val;
          unique case (cmd_q) inside
            lcg64ru_pkg::CmdUniform52: begin
              res_d   = lcg64ru_pkg::LcgW'(frac52);
              state_d = lcg64ru_pkg::StFinish;
            end
            lcg64ru_pkg::CmdUniform23: begin
              res_d   = lcg64ru_pkg::LcgW'(frac23);
              state_d = lcg64ru_pkg::StFinish;
            end
            lcg64ru_pkg::CmdRange, lcg64ru_pkg::CmdBetween: begin
              if (step_val >= lim_q) begin
                mul_req.start = 1'b1;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = step_val;
                state_d          = lcg64ru_pkg::StMod;
              end
            end
            lcg64ru_pkg::CmdGauss52, lcg64ru_pkg::CmdGauss23: begin
              if (cmd_q == lcg64ru_pkg::CmdGauss52) begin
                sum_d = sum_q + lcg64ru_pkg::GaussW'(frac52);
              end else begin
                sum_d = sum_q + lcg64ru_pkg::GaussW'(
                    {frac23, {(lcg64ru_pkg::FracW - lcg64ru_pkg::Frac23W){1'b0}}});
              end
              cnt_d = cnt_q + 1'b1;
              if (cnt_q == lcg64ru_pkg::GaussCntW'(lcg64ru_pkg::GaussTerms - 1)) begin
                state_d = lcg64ru_pkg::StFinish;
              end else begin
                mul_req.start = 1'b1;
              end
            end
            default: begin
              res_d   = step_val;
              state_d = lcg64ru_pkg::StFinish;
            end
          endcase
        end
      end

      lcg64ru_pkg::StMod: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.remainder + offset_q;
          state_d = lcg64ru_pkg::StFinish;
        end
      end

      lcg64ru_pkg::StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          rand_value_d  = res_q;
          bound_error_d = err_q;
          if ((cmd_q == lcg64ru_pkg::CmdGauss52) || (cmd_q == lcg64ru_pkg::CmdGauss23)) begin
            gauss_value_d = sum_q - lcg64ru_pkg::SixQ52;
          end else begin
            gauss_value_d = '0;
          end
          state_d = lcg64ru_pkg::StIdle;
        end
      end

      default: begin
        state_d = lcg64ru_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcg64ru_pkg::StIdle;
      lcg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    bound_q       <= bound_d;
    offset_q      <= offset_d;
    lim_q         <= lim_d;
    res_q         <= res_d;
    sum_q         <= sum_d;
    cnt_q         <= cnt_d;
    err_q         <= err_d;
    rand_value_q  <= rand_value_d;
    gauss_value_q <= gauss_value_d;
    bound_error_q <= bound_error_d;
  end

  assign out_valid_o   = out_valid_q;
  assign rand_value_o  = rand_value_q;
  assign gauss_value_o = $signed(gauss_value_q);
  assign bound_error_o = bound_error_q;

  `LCG_NEVER(a_units_exclusive, mul_rsp.busy && div_rsp.busy)
  `LCG_ASSERT(a_err_zero_payload,
      out_valid_o && bound_error_o |-> (rand_value_o == '0) && (gauss_value_o == '0))
  `LCG_ASSERT(a_one_payload_used, out_valid_o && (gauss_value_o != '0) |-> rand_value_o == '0)
  `LCG_ASSERT(a_state_held_idle,
      (state_q == lcg64ru_pkg::StIdle) && !in_valid_i |=> $stable(lcg_q))
  `LCG_ASSERT(a_accepted_below_limit, (state_q == lcg64ru_pkg::StMod) |-> (lcg_q < lim_q))

endmodule
